### sv/m3ema_pkg.sv
// Shared constants and word types for the median-of-three adaptive EMA filter.
package m3ema_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int FRACTION_BITS  = 8;
	localparam int COARSE_BITS    = 8;
	localparam int COARSE_SHIFT   = SAMPLE_BITS - COARSE_BITS;
	localparam int COUNT_BITS     = 12;
	localparam int SHIFT_BITS     = 4;
	localparam int CFG_DATA_BITS  = 12;
	localparam int CFG_INDEX_BITS = 3;
	localparam int SLOT_BITS      = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_HOLD_COUNTS = 3'd0,
		REG_FAST_COUNTS = 3'd1,
		REG_SLOW_SHIFT  = 3'd2,
		REG_FAST_SHIFT  = 3'd3
	} reg_index_t;

	localparam logic [COUNT_BITS-1:0] HOLD_COUNTS_RESET = COUNT_BITS'(2);
	localparam logic [COUNT_BITS-1:0] FAST_COUNTS_RESET = COUNT_BITS'(64);
	localparam logic [SHIFT_BITS-1:0] SLOW_SHIFT_RESET  = SHIFT_BITS'(3);
	localparam logic [SHIFT_BITS-1:0] FAST_SHIFT_RESET  = SHIFT_BITS'(1);

	typedef enum logic {
		MODE_SEED   = 1'b0,
		MODE_UPDATE = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [SAMPLE_BITS-1:0] sample;
	} in_word_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] raw_sample;
		logic [SAMPLE_BITS-1:0] filtered_value;
		logic [COARSE_BITS-1:0] raw_coarse;
		logic [COARSE_BITS-1:0] filtered_coarse;
	} out_word_t;

endpackage

### sv/median3_adaptive_ema_filter.sv
// Median-of-three spike filter followed by an adaptive fixed-point moving average.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   in_word  (mode, sample)
//   out      source     out_valid / out_stall out_word (raw, filtered, coarse)
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// Each word is held in the input register while the datapath computes into the
// output register; its result passes the input register and then the output register,
// and one word is taken every cycle unless the output stalls. The filter state updates
// as a word enters the output register, which keeps the median, compare and shift
// combinational between the two registers. Reset restores the register defaults and
// clears the history and filter. A stall on the output holds the result and backs up through the input register.
module median3_adaptive_ema_filter #(
	parameter int FRACTION_BITS = m3ema_pkg::FRACTION_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  m3ema_pkg::in_word_t                      in_word,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output m3ema_pkg::out_word_t                     out_word,
	input  logic                                     cfg_we,
	input  logic [m3ema_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [m3ema_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int SB = m3ema_pkg::SAMPLE_BITS;
	localparam int CB = m3ema_pkg::COUNT_BITS;
	localparam int QW = SB + FRACTION_BITS;
	localparam int TW = (SB > CB) ? SB : CB;
	localparam int CW = TW + FRACTION_BITS;
	localparam int RW = QW + 1;
	localparam logic [m3ema_pkg::SLOT_BITS-1:0] SLOT_LAST = m3ema_pkg::SLOT_BITS'(2);

	// Configuration registers
	logic [CB-1:0]                    hold_q, fast_q;
	logic [m3ema_pkg::SHIFT_BITS-1:0] slow_sh_q, fast_sh_q;

	// Filter state
	logic [SB-1:0]                    hist_q [3];
	logic [m3ema_pkg::SLOT_BITS-1:0]  slot_q;
	logic [QW-1:0]                    filt_q;

	// Pipeline
	m3ema_pkg::in_word_t  in_s1;
	logic                 valid_s1;
	m3ema_pkg::out_word_t out_q;
	logic                 out_valid_q;
	logic                 take;

	assign take      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !take;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= m3ema_pkg::HOLD_COUNTS_RESET;
			fast_q    <= m3ema_pkg::FAST_COUNTS_RESET;
			slow_sh_q <= m3ema_pkg::SLOW_SHIFT_RESET;
			fast_sh_q <= m3ema_pkg::FAST_SHIFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				m3ema_pkg::REG_HOLD_COUNTS: hold_q    <= cfg_data[CB-1:0];
				m3ema_pkg::REG_FAST_COUNTS: fast_q    <= cfg_data[CB-1:0];
				m3ema_pkg::REG_SLOW_SHIFT:  slow_sh_q <= cfg_data[m3ema_pkg::SHIFT_BITS-1:0];
				m3ema_pkg::REG_FAST_SHIFT:  fast_sh_q <= cfg_data[m3ema_pkg::SHIFT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Datapath for the word in the input register
	logic [m3ema_pkg::SLOT_BITS-1:0]  slot_use, slot_next;
	logic [SB-1:0]                    h0, h1, h2, lo01, hi01, med;
	logic [QW-1:0]                    target, diff, step, filt_upd, filt_next;
	logic                             up;
	logic [CW-1:0]                    diff_ext, hold_scaled, fast_scaled;
	logic [m3ema_pkg::SHIFT_BITS-1:0] sh;
	logic [RW-1:0]                    rnd_sum;
	logic [RW-FRACTION_BITS-1:0]      rnd_wide;
	logic [SB-1:0]                    rounded;
	logic [SB-1:0]                    s;

	always_comb begin
		s         = in_s1.sample;
		slot_use  = (slot_q > SLOT_LAST) ? '0 : slot_q;
		slot_next = (slot_use == SLOT_LAST) ? '0 : slot_use + 1'b1;
		h0 = (slot_use == 2'd0) ? s : hist_q[0];
		h1 = (slot_use == 2'd1) ? s : hist_q[1];
		h2 = (slot_use == SLOT_LAST) ? s : hist_q[2];
		lo01 = (h0 < h1) ? h0 : h1;
		hi01 = (h0 < h1) ? h1 : h0;
		med  = (hi01 < h2) ? hi01 : ((lo01 > h2) ? lo01 : h2);

		target = QW'(med) << FRACTION_BITS;
		up     = target >= filt_q;
		diff   = up ? target - filt_q : filt_q - target;

		diff_ext    = CW'(diff);
		hold_scaled = CW'(hold_q) << FRACTION_BITS;
		fast_scaled = CW'(fast_q) << FRACTION_BITS;
		sh   = (diff_ext >= fast_scaled) ? fast_sh_q : slow_sh_q;
		step = diff >> sh;

		if (diff_ext > hold_scaled) begin
			filt_upd = up ? filt_q + step : filt_q - step;
		end else begin
			filt_upd = filt_q;
		end

		filt_next = (in_s1.mode == m3ema_pkg::MODE_SEED) ? QW'(s) << FRACTION_BITS : filt_upd;

		rnd_sum  = RW'(filt_next) + (RW'(1) << (FRACTION_BITS - 1));
		rnd_wide = rnd_sum[RW-1:FRACTION_BITS];
		rounded  = rnd_wide[SB] ? {SB{1'b1}} : rnd_wide[SB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			filt_q      <= '0;
			hist_q[0]   <= '0;
			hist_q[1]   <= '0;
			hist_q[2]   <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				filt_q      <= filt_next;
				if (in_s1.mode == m3ema_pkg::MODE_SEED) begin
					hist_q[0] <= s;
					hist_q[1] <= s;
					hist_q[2] <= s;
					slot_q    <= '0;
				end else begin
					hist_q[0] <= h0;
					hist_q[1] <= h1;
					hist_q[2] <= h2;
					slot_q    <= slot_next;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_word;
		end
		if (take) begin
			out_q.raw_sample      <= s;
			out_q.filtered_value  <= rounded;
			out_q.raw_coarse      <= s[SB-1 -: m3ema_pkg::COARSE_BITS];
			out_q.filtered_coarse <= rounded[SB-1 -: m3ema_pkg::COARSE_BITS];
		end
	end

	// The ring pointer only ever walks through the three history slots.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != 2'd3)
		else $error("history slot pointer left its range");

	// The average never climbs past the largest possible target.
	a_filter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filt_q <= (QW'({SB{1'b1}}) << FRACTION_BITS))
		else $error("filter state above largest sample");

	// A word leaving the input register always lands as a valid result.
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("computed word not presented");

	// The input side only backs up while a word is held in the input register and the held result is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a full pipeline");

endmodule
